### rtl/rkc_pkg.sv
// shared types and constants of the rgb 3x3 kernel convolution block
package rkc_pkg;

  localparam int unsigned PIX_W     = 24;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;
  localparam int unsigned DIV_W     = 12;
  localparam int unsigned SUM_W     = 20;
  localparam int unsigned MAG_W     = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF_TOP    = 3'd0,
    REG_COEFF_MIDDLE = 3'd1,
    REG_COEFF_BOTTOM = 3'd2,
    REG_DIVISOR      = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5
  } reg_idx_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic signed [SUM_W-1:0] sum_t;

endpackage

### rtl/rgb_kernel_convolution.sv
// top level of the rgb 3x3 kernel convolution block
// usage:
//   pixels enter in raster order on the in_ request channel (valid/ready),
//   one request per pixel; results leave on the out_ channel (valid/ready)
//   only for interior pixels, centred one row and one column behind.
//   the cfg_ channel writes kernel rows, divisor and image size by index;
//   writes are taken at any time and must only be issued while idle.
// sequence:
//   a border pixel only does the line store read and write back; an
//   interior pixel then goes on to multiply-accumulate over all taps of the
//   3x3 window (one tap per cycle, one multiplier per channel), bit-serial
//   division and the load of the output register, and the next pixel is
//   accepted only after that load.
// reset:
//   counters and window clear, registers take their defaults (kernel rows
//   0, 0x010000, 0, divisor 1, 640x480); line store contents are undefined.
// stall:
//   the result sits in an output register; the next pixel is accepted
//   while it waits, and the block holds a new result until it is taken.
module rgb_kernel_convolution
  import rkc_pkg::*;
#(
  parameter int unsigned MAX_LINE_WIDTH   = 1024,
  parameter int unsigned MAX_FRAME_HEIGHT = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CH_W-1:0]      in_red_i,
  input  logic [CH_W-1:0]      in_green_i,
  input  logic [CH_W-1:0]      in_blue_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CH_W-1:0]      out_red_o,
  output logic [CH_W-1:0]      out_green_o,
  output logic [CH_W-1:0]      out_blue_o,
  output logic                 frame_done_o
);

  localparam int unsigned AW = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned RW = $clog2(MAX_FRAME_HEIGHT);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_MAC, S_DIV, S_OUT} state_e;

  state_e state_q;
  logic [23:0] coef_q [3];
  logic [DIV_W-1:0] div_q;
  logic [10:0] width_q;
  logic [12:0] height_q;

  pix_t upper_mem [MAX_LINE_WIDTH];
  pix_t lower_mem [MAX_LINE_WIDTH];
  pix_t upper_rd_q, lower_rd_q;
  logic mem_we;

  pix_t pix_q;
  pix_t wreg_q [6];
  pix_t win_q [3][3];
  logic [AW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic done_q;
  logic [1:0] ti_q, tk_q;
  logic [4:0] step_q;
  sum_t acc_q [3];
  logic [MAG_W-1:0] nq_q [3];
  logic [DIV_W-1:0] rem_q [3];

  logic out_valid_q, out_done_q;
  logic [CH_W-1:0] out_ch_q [3];

  logic [AW:0] w_eff;
  logic [RW:0] h_eff;
  logic [DIV_W-1:0] d_eff;
  logic [AW:0] col_inc;
  logic [RW:0] row_inc;
  pix_t col_v [3];
  logic signed [CH_W-1:0] kc;
  sum_t prod [3];
  logic [DIV_W:0] rem_sh [3];
  logic ge [3];
  logic in_acc;
  logic out_load;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign mem_we      = (state_q == S_READ);
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    if (width_q < 11'd3) w_eff = (AW+1)'(3);
    else if (32'(width_q) > MAX_LINE_WIDTH) w_eff = (AW+1)'(MAX_LINE_WIDTH);
    else w_eff = (AW+1)'(width_q);
    if (height_q < 13'd3) h_eff = (RW+1)'(3);
    else if (32'(height_q) > MAX_FRAME_HEIGHT) h_eff = (RW+1)'(MAX_FRAME_HEIGHT);
    else h_eff = (RW+1)'(height_q);
    d_eff   = (div_q == '0) ? DIV_W'(1) : div_q;
    col_inc = {1'b0, col_q} + (AW+1)'(1);
    row_inc = {1'b0, row_q} + (RW+1)'(1);
    col_v[0] = upper_rd_q;
    col_v[1] = lower_rd_q;
    col_v[2] = pix_q;
    kc = $signed(coef_q[ti_q][8*tk_q +: 8]);
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch]   = SUM_W'(kc * $signed({1'b0, win_q[ti_q][tk_q][8*(2-ch) +: 8]}));
      rem_sh[ch] = {rem_q[ch], nq_q[ch][MAG_W-1]};
      ge[ch]     = rem_sh[ch] >= {1'b0, d_eff};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      upper_rd_q <= upper_mem[col_q];
      lower_rd_q <= lower_mem[col_q];
    end
    if (mem_we) begin
      upper_mem[col_q] <= lower_rd_q;
      lower_mem[col_q] <= pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      coef_q[0]   <= '0;
      coef_q[1]   <= 24'h010000;
      coef_q[2]   <= '0;
      div_q       <= DIV_W'(1);
      width_q     <= 11'd640;
      height_q    <= 13'd480;
      for (int i = 0; i < 6; i++) wreg_q[i] <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_COEFF_TOP:    coef_q[0] <= cfg_data_i;
          REG_COEFF_MIDDLE: coef_q[1] <= cfg_data_i;
          REG_COEFF_BOTTOM: coef_q[2] <= cfg_data_i;
          REG_DIVISOR:      div_q    <= cfg_data_i[DIV_W-1:0];
          REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[10:0];
          REG_IMAGE_HEIGHT: height_q <= cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            pix_q   <= {in_red_i, in_green_i, in_blue_i};
            state_q <= S_READ;
          end
        end
        S_READ: begin
          for (int i = 0; i < 3; i++) begin
            win_q[i][0]    <= wreg_q[2*i];
            win_q[i][1]    <= wreg_q[2*i+1];
            win_q[i][2]    <= col_v[i];
            wreg_q[2*i]    <= wreg_q[2*i+1];
            wreg_q[2*i+1]  <= col_v[i];
            acc_q[i]       <= '0;
          end
          done_q <= (col_inc >= w_eff) && (row_inc >= h_eff);
          ti_q   <= '0;
          tk_q   <= '0;
          if (col_inc >= w_eff) begin
            col_q <= '0;
            row_q <= (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
          end else begin
            col_q <= col_inc[AW-1:0];
            if (row_q >= h_eff) row_q <= '0;
          end
          state_q <= (col_q >= AW'(2) && row_q >= RW'(2)) ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          for (int ch = 0; ch < 3; ch++) acc_q[ch] <= acc_q[ch] + prod[ch];
          if (tk_q == 2'd2) begin
            tk_q <= '0;
            ti_q <= ti_q + 2'd1;
            if (ti_q == 2'd2) begin
              state_q <= S_DIV;
              step_q  <= '0;
            end
          end else begin
            tk_q <= tk_q + 2'd1;
          end
          if (ti_q == 2'd2 && tk_q == 2'd2) begin
            for (int ch = 0; ch < 3; ch++) begin
              nq_q[ch]  <= (acc_q[ch] + prod[ch]) < 0 ?
                           MAG_W'(-(acc_q[ch] + prod[ch])) :
                           MAG_W'(acc_q[ch] + prod[ch]);
              rem_q[ch] <= '0;
            end
          end
        end
        S_DIV: begin
          for (int ch = 0; ch < 3; ch++) begin
            rem_q[ch] <= ge[ch] ? DIV_W'(rem_sh[ch] - {1'b0, d_eff})
                                : DIV_W'(rem_sh[ch]);
            nq_q[ch]  <= {nq_q[ch][MAG_W-2:0], ge[ch]};
          end
          step_q <= step_q + 5'd1;
          if (step_q == 5'(MAG_W - 1)) state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            for (int ch = 0; ch < 3; ch++)
              out_ch_q[ch] <= (nq_q[ch] > MAG_W'(255)) ? 8'd255 : nq_q[ch][7:0];
            out_done_q  <= done_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_red_o    = out_ch_q[0];
  assign out_green_o  = out_ch_q[1];
  assign out_blue_o   = out_ch_q[2];
  assign frame_done_o = out_done_q;

endmodule
